/* hw/rtl/fat_chain_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// FAT chain engine assertion macros
// Shared assertion macros for the FAT chain engine.
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_ENGINE_TOP_DEFINES_SVH
`define FAT_CHAIN_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FCE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("FCE assertion failed");
`define FCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("FCE assertion failed");
`else
`define FCE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define FCE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/fce_pkg.sv */
// ----------------------------------------------------------------------------
// FAT chain engine package
// Types, codes and constants shared by the FAT chain engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fce_pkg;

   localparam int TABLE_ENTRIES = 4096;
   localparam int BLOCK_BYTES   = 4096;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int LIM_W         = ADDR_W + 1;
   localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
   localparam int ENTRY_W       = 16;
   localparam int OFS_W         = 24;
   localparam int COUNT_W       = 12;
   localparam int CSR_W         = 16;
   localparam int DBC_W         = 13;

   localparam logic [ENTRY_W-1:0] CHAIN_END  = 16'hFFFF;
   localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'h0000;

   typedef enum logic [2:0] {
      OP_NEW_CHAIN  = 3'd0,
      OP_APPEND     = 3'd1,
      OP_FREE_CHAIN = 3'd2,
      OP_LOOKUP     = 3'd3,
      OP_COUNT_FREE = 3'd4,
      OP_READ_ENTRY = 3'd5,
      OP_WRITE_ENTRY = 3'd6,
      OP_UNUSED     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_PAST_END   = 2'd2,
      STATUS_BAD_CHAIN  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_DATA_BLOCK_COUNT = 1'b0,
      CSR_DATA_START       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [11:0]        chain_head;
      logic [OFS_W-1:0]   byte_offset;
      logic [ENTRY_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] block_index;
      logic [COUNT_W-1:0] free_count;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] wdata;
   } ram_cmd_type;

endpackage

/* hw/rtl/fat_chain_engine_top.sv */
// ----------------------------------------------------------------------------
// FAT chain engine
// Allocates, walks, frees and scans chains in a 16-bit file allocation table,
// and reads or writes raw table entries.
//  Channel  Ports                          Role
//  req      req_valid req_ready req_data   one operation item in
//  rsp      rsp_valid rsp_ready rsp_data   one result item out
//  csr      csr_we csr_index csr_wdata     register writes, no read-back
//
// Every table entry visited uses the single memory port first to issue the
// read and then to act on the data. New chain, append and count scan from
// entry one; walks take one entry per hop. After reset all 4096 table entries
// are cleared, and no item is accepted until that is done. A waiting result
// does not block acceptance; a finished item holds in its last state until
// the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fat_chain_engine_top_defines.svh"

module fat_chain_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fce_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fce_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [fce_pkg::CSR_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_LINK,
      ST_FREE_RD,
      ST_FREE_EV,
      ST_LOOK_RD,
      ST_LOOK_EV,
      ST_RAW_RD,
      ST_RAW_EV,
      ST_RAW_WR,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   fce_pkg::op_type                    op_ff;
   logic [fce_pkg::ADDR_W-1:0]         clr_ff;
   logic [fce_pkg::ADDR_W-1:0]         cur_ff;
   logic [fce_pkg::LIM_W-1:0]          idx_ff;
   logic [fce_pkg::OFS_W-1:0]          step_ff;
   logic [fce_pkg::OFS_W-1:0]          hop_ff;
   logic [fce_pkg::COUNT_W-1:0]        cnt_ff;
   logic [fce_pkg::ENTRY_W-1:0]        val_ff;
   fce_pkg::rsp_type                   res_ff;
   fce_pkg::rsp_type                   rsp_data_ff;
   logic                               rsp_valid_ff;
   logic [fce_pkg::DBC_W-1:0]          dbc_ff;
   logic [fce_pkg::ENTRY_W-1:0]        dstart_ff;

   fce_pkg::ram_cmd_type               ram_cmd;
   logic [fce_pkg::ENTRY_W-1:0]        rd_data;
   logic [fce_pkg::LIM_W-1:0]          limit;
   logic                               head_ok;
   logic                               raw_ok;
   logic                               accept;
   logic                               v_in_range;
   logic [fce_pkg::OFS_W-1:0]          step_inc;

   fce_table_ram u_table (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      if ({1'b0, dbc_ff} < (fce_pkg::DBC_W + 1)'(fce_pkg::TABLE_ENTRIES)) begin
         limit = fce_pkg::LIM_W'(dbc_ff);
      end else begin
         limit = fce_pkg::LIM_W'(fce_pkg::TABLE_ENTRIES);
      end
   end

   assign head_ok = (req_data.chain_head != '0) &&
                    (fce_pkg::LIM_W'(req_data.chain_head) < limit);
   assign raw_ok  = (fce_pkg::LIM_W'(req_data.chain_head) <
                     fce_pkg::LIM_W'(fce_pkg::TABLE_ENTRIES));
   assign accept  = req_valid && req_ready;
   assign v_in_range = ({1'b0, rd_data} < (fce_pkg::ENTRY_W + 1)'(limit));
   assign step_inc   = step_ff + fce_pkg::OFS_W'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ram_cmd.we    = 1'b0;
      ram_cmd.addr  = cur_ff;
      ram_cmd.wdata = fce_pkg::ENTRY_FREE;
      case (state_ff)
         ST_CLEAR: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.addr  = clr_ff;
            ram_cmd.wdata = (clr_ff == '0) ? fce_pkg::CHAIN_END : fce_pkg::ENTRY_FREE;
         end
         ST_SCAN_RD: begin
            ram_cmd.addr = idx_ff[fce_pkg::ADDR_W-1:0];
         end
         ST_SCAN_EV: begin
            ram_cmd.addr = idx_ff[fce_pkg::ADDR_W-1:0];
            if ((op_ff != fce_pkg::OP_COUNT_FREE) && (rd_data == fce_pkg::ENTRY_FREE)) begin
               ram_cmd.we    = 1'b1;
               ram_cmd.wdata = fce_pkg::CHAIN_END;
            end
         end
         ST_FREE_EV: begin
            ram_cmd.we    = (rd_data != fce_pkg::ENTRY_FREE);
            ram_cmd.wdata = fce_pkg::ENTRY_FREE;
         end
         ST_LINK: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.wdata = fce_pkg::ENTRY_W'(idx_ff);
         end
         ST_RAW_WR: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.wdata = val_ff;
         end
         default: begin
            ram_cmd.we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbc_ff    <= fce_pkg::DBC_W'(4096);
         dstart_ff <= fce_pkg::ENTRY_W'(4);
      end else if (csr_we) begin
         case (fce_pkg::csr_index_type'(csr_index))
            fce_pkg::CSR_DATA_BLOCK_COUNT: dbc_ff    <= csr_wdata[fce_pkg::DBC_W-1:0];
            fce_pkg::CSR_DATA_START:       dstart_ff <= csr_wdata;
            default:                       dstart_ff <= dstart_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + fce_pkg::ADDR_W'(1);
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  op_ff   <= fce_pkg::op_type'(req_data.op);
                  cur_ff  <= fce_pkg::ADDR_W'(req_data.chain_head);
                  val_ff  <= req_data.entry_value;
                  hop_ff  <= req_data.byte_offset >> fce_pkg::BLOCK_SHIFT;
                  idx_ff  <= fce_pkg::LIM_W'(1);
                  step_ff <= '0;
                  cnt_ff  <= '0;
                  res_ff.block_index <= '0;
                  res_ff.free_count  <= '0;
                  case (fce_pkg::op_type'(req_data.op))
                     fce_pkg::OP_NEW_CHAIN, fce_pkg::OP_COUNT_FREE: begin
                        state_ff      <= ST_SCAN_RD;
                        res_ff.status <= fce_pkg::STATUS_OK;
                     end
                     fce_pkg::OP_APPEND: begin
                        state_ff <= head_ok ? ST_WALK_RD : ST_DONE;
                        res_ff.status <= head_ok ? fce_pkg::STATUS_OK
                                                 : fce_pkg::STATUS_BAD_CHAIN;
                     end
                     fce_pkg::OP_FREE_CHAIN: begin
                        state_ff <= head_ok ? ST_FREE_RD : ST_DONE;
                        res_ff.status <= head_ok ? fce_pkg::STATUS_OK
                                                 : fce_pkg::STATUS_BAD_CHAIN;
                     end
                     fce_pkg::OP_LOOKUP: begin
                        state_ff <= head_ok ? ST_LOOK_RD : ST_DONE;
                        res_ff.status <= head_ok ? fce_pkg::STATUS_OK
                                                 : fce_pkg::STATUS_BAD_CHAIN;
                     end
                     fce_pkg::OP_READ_ENTRY: begin
                        state_ff <= raw_ok ? ST_RAW_RD : ST_DONE;
                        res_ff.status <= raw_ok ? fce_pkg::STATUS_OK
                                                : fce_pkg::STATUS_BAD_CHAIN;
                     end
                     fce_pkg::OP_WRITE_ENTRY: begin
                        state_ff <= raw_ok ? ST_RAW_WR : ST_DONE;
                        res_ff.status <= raw_ok ? fce_pkg::STATUS_OK
                                                : fce_pkg::STATUS_BAD_CHAIN;
                     end
                     default: begin
                        state_ff      <= ST_DONE;
                        res_ff.status <= fce_pkg::STATUS_BAD_CHAIN;
                     end
                  endcase
               end
            end
            ST_SCAN_RD: begin
               if (idx_ff >= limit) begin
                  state_ff <= ST_DONE;
                  if (op_ff == fce_pkg::OP_COUNT_FREE) begin
                     res_ff.free_count <= cnt_ff;
                  end else begin
                     res_ff.status <= fce_pkg::STATUS_FULL;
                  end
               end else begin
                  state_ff <= ST_SCAN_EV;
               end
            end
            ST_SCAN_EV: begin
               if (rd_data == fce_pkg::ENTRY_FREE && op_ff != fce_pkg::OP_COUNT_FREE) begin
                  res_ff.block_index <= fce_pkg::ENTRY_W'(idx_ff);
                  state_ff <= (op_ff == fce_pkg::OP_APPEND) ? ST_LINK : ST_DONE;
               end else begin
                  if (rd_data == fce_pkg::ENTRY_FREE && cnt_ff != '1) begin
                     cnt_ff <= cnt_ff + fce_pkg::COUNT_W'(1);
                  end
                  idx_ff   <= idx_ff + fce_pkg::LIM_W'(1);
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_WALK_RD: begin
               state_ff <= ST_WALK_EV;
            end
            ST_WALK_EV: begin
               if (rd_data == fce_pkg::CHAIN_END) begin
                  state_ff <= ST_SCAN_RD;
               end else if (rd_data == fce_pkg::ENTRY_FREE || !v_in_range ||
                            step_inc >= fce_pkg::OFS_W'(limit)) begin
                  res_ff.status <= fce_pkg::STATUS_BAD_CHAIN;
                  state_ff      <= ST_DONE;
               end else begin
                  cur_ff   <= rd_data[fce_pkg::ADDR_W-1:0];
                  step_ff  <= step_inc;
                  state_ff <= ST_WALK_RD;
               end
            end
            ST_LINK: begin
               state_ff <= ST_DONE;
            end
            ST_FREE_RD: begin
               if (step_ff >= fce_pkg::OFS_W'(limit)) begin
                  res_ff.status <= fce_pkg::STATUS_BAD_CHAIN;
                  state_ff      <= ST_DONE;
               end else begin
                  state_ff <= ST_FREE_EV;
               end
            end
            ST_FREE_EV: begin
               if (rd_data == fce_pkg::ENTRY_FREE || (rd_data != fce_pkg::CHAIN_END &&
                                                     !v_in_range)) begin
                  res_ff.status <= fce_pkg::STATUS_BAD_CHAIN;
                  state_ff      <= ST_DONE;
               end else if (rd_data == fce_pkg::CHAIN_END) begin
                  state_ff <= ST_DONE;
               end else begin
                  cur_ff   <= rd_data[fce_pkg::ADDR_W-1:0];
                  step_ff  <= step_inc;
                  state_ff <= ST_FREE_RD;
               end
            end
            ST_LOOK_RD: begin
               state_ff <= ST_LOOK_EV;
            end
            ST_LOOK_EV: begin
               if (rd_data == fce_pkg::ENTRY_FREE) begin
                  res_ff.status <= fce_pkg::STATUS_BAD_CHAIN;
                  state_ff      <= ST_DONE;
               end else if (step_ff == hop_ff) begin
                  res_ff.block_index <= fce_pkg::ENTRY_W'(cur_ff) + dstart_ff;
                  state_ff           <= ST_DONE;
               end else if (rd_data == fce_pkg::CHAIN_END) begin
                  res_ff.status <= fce_pkg::STATUS_PAST_END;
                  state_ff      <= ST_DONE;
               end else if (!v_in_range || step_inc >= fce_pkg::OFS_W'(limit)) begin
                  res_ff.status <= fce_pkg::STATUS_BAD_CHAIN;
                  state_ff      <= ST_DONE;
               end else begin
                  cur_ff   <= rd_data[fce_pkg::ADDR_W-1:0];
                  step_ff  <= step_inc;
                  state_ff <= ST_LOOK_RD;
               end
            end
            ST_RAW_RD: begin
               state_ff <= ST_RAW_EV;
            end
            ST_RAW_EV: begin
               res_ff.block_index <= rd_data;
               state_ff           <= ST_DONE;
            end
            ST_RAW_WR: begin
               res_ff.block_index <= val_ff;
               state_ff           <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `FCE_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready)
   `FCE_ASSERT_SAME(a_error_has_no_block, clock, reset,
                    rsp_valid && rsp_data.status != fce_pkg::STATUS_OK,
                    rsp_data.block_index == '0)
   `FCE_ASSERT_SAME(a_count_only_when_ok, clock, reset,
                    rsp_valid && rsp_data.free_count != '0,
                    rsp_data.status == fce_pkg::STATUS_OK)

endmodule

/* hw/rtl/fce_table_ram.sv */
// ----------------------------------------------------------------------------
// FAT chain engine table memory
// Single-port table memory with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fce_table_ram (
   input  logic                                clock,
   input  fce_pkg::ram_cmd_type                cmd,
   output logic [fce_pkg::ENTRY_W-1:0]         rd_data
);

   logic [fce_pkg::ENTRY_W-1:0] mem [fce_pkg::TABLE_ENTRIES];
   logic [fce_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      rd_data_ff <= mem[cmd.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/tb_fat_chain_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT chain engine testbench
// Drives table operations through the request channel and checks each result
// against a shadow copy of the allocation table. A short directed pass covers
// chain building, walks past the end, broken links, full tables and raw access;
// random phases under several layouts follow, mostly well-formed chain work on
// heads the shadow knows about, mixed with raw writes and noise.
// ----------------------------------------------------------------------------

class fat_table_shadow;
   bit [fce_pkg::ENTRY_W-1:0] entries [fce_pkg::TABLE_ENTRIES];
   int unsigned               block_count;
   bit [fce_pkg::ENTRY_W-1:0] data_start;
   fce_pkg::rsp_type          pending_results [$];
   int unsigned               live_heads [$];
   int                        errors;
   int                        accepted;
   int                        checked;

   function new();
      foreach (entries[i]) entries[i] = fce_pkg::ENTRY_FREE;
      entries[0] = fce_pkg::CHAIN_END;
      block_count = 4096;
      data_start = 16'd4;
      errors = 0;
      accepted = 0;
      checked = 0;
   endfunction

   function void write_register(input fce_pkg::csr_index_type idx,
                                input bit [fce_pkg::CSR_W-1:0] value);
      if (idx == fce_pkg::CSR_DATA_BLOCK_COUNT) begin
         block_count = value[fce_pkg::DBC_W-1:0];
      end else begin
         data_start = value;
      end
   endfunction

   function int unsigned usable_limit();
      return (block_count < fce_pkg::TABLE_ENTRIES) ? block_count : fce_pkg::TABLE_ENTRIES;
   endfunction

   function int unsigned first_free(input int unsigned lim);
      for (int unsigned i = 1; i < lim; i++) begin
         if (entries[i] == fce_pkg::ENTRY_FREE) return i;
      end
      return 0;
   endfunction

   function void apply_request(input fce_pkg::req_type item);
      fce_pkg::rsp_type r;
      int unsigned      lim;
      int unsigned      head;
      int unsigned      cur;
      int unsigned      hops;
      int unsigned      n;
      int unsigned      v;
      bit               head_ok;
      r = '0;
      lim = usable_limit();
      head = item.chain_head;
      head_ok = (head >= 1) && (head < lim);
      accepted++;
      case (item.op)
         fce_pkg::OP_NEW_CHAIN: begin
            n = first_free(lim);
            if (n == 0) begin
               r.status = fce_pkg::STATUS_FULL;
            end else begin
               entries[n] = fce_pkg::CHAIN_END;
               r.block_index = fce_pkg::ENTRY_W'(n);
               live_heads.push_back(n);
            end
         end
         fce_pkg::OP_APPEND: begin
            if (!head_ok) begin
               r.status = fce_pkg::STATUS_BAD_CHAIN;
            end else begin
               cur = head;
               hops = 0;
               while (1'b1) begin
                  v = entries[cur];
                  if (v == fce_pkg::CHAIN_END) break;
                  if (v == 0 || v >= lim) begin
                     r.status = fce_pkg::STATUS_BAD_CHAIN;
                     break;
                  end
                  cur = v;
                  hops++;
                  if (hops >= lim) begin
                     r.status = fce_pkg::STATUS_BAD_CHAIN;
                     break;
                  end
               end
               if (r.status == fce_pkg::STATUS_OK) begin
                  n = first_free(lim);
                  if (n == 0) begin
                     r.status = fce_pkg::STATUS_FULL;
                  end else begin
                     entries[cur] = fce_pkg::ENTRY_W'(n);
                     entries[n] = fce_pkg::CHAIN_END;
                     r.block_index = fce_pkg::ENTRY_W'(n);
                  end
               end
            end
         end
         fce_pkg::OP_FREE_CHAIN: begin
            if (!head_ok) begin
               r.status = fce_pkg::STATUS_BAD_CHAIN;
            end else begin
               r.status = fce_pkg::STATUS_BAD_CHAIN;
               cur = head;
               for (int unsigned k = 0; k < lim; k++) begin
                  v = entries[cur];
                  if (v == 0) break;
                  entries[cur] = fce_pkg::ENTRY_FREE;
                  if (v == fce_pkg::CHAIN_END) begin
                     r.status = fce_pkg::STATUS_OK;
                     break;
                  end
                  if (v >= lim) break;
                  cur = v;
               end
            end
            for (int k = 0; k < live_heads.size(); k++) begin
               if (live_heads[k] == head) begin
                  live_heads.delete(k);
                  break;
               end
            end
         end
         fce_pkg::OP_LOOKUP: begin
            hops = item.byte_offset / fce_pkg::BLOCK_BYTES;
            if (!head_ok || entries[head] == fce_pkg::ENTRY_FREE) begin
               r.status = fce_pkg::STATUS_BAD_CHAIN;
            end else begin
               cur = head;
               for (int unsigned i = 0; i < hops; i++) begin
                  v = entries[cur];
                  if (v == fce_pkg::CHAIN_END) begin
                     r.status = fce_pkg::STATUS_PAST_END;
                     break;
                  end
                  if (v >= lim || i + 1 >= lim) begin
                     r.status = fce_pkg::STATUS_BAD_CHAIN;
                     break;
                  end
                  cur = v;
                  if (entries[cur] == fce_pkg::ENTRY_FREE) begin
                     r.status = fce_pkg::STATUS_BAD_CHAIN;
                     break;
                  end
               end
               if (r.status == fce_pkg::STATUS_OK)
                  r.block_index = fce_pkg::ENTRY_W'(cur + data_start);
            end
         end
         fce_pkg::OP_COUNT_FREE: begin
            n = 0;
            for (int unsigned i = 1; i < lim; i++) begin
               if (entries[i] == fce_pkg::ENTRY_FREE) n++;
            end
            r.free_count = (n > 4095) ? {fce_pkg::COUNT_W{1'b1}} : fce_pkg::COUNT_W'(n);
         end
         fce_pkg::OP_READ_ENTRY: begin
            if (head < fce_pkg::TABLE_ENTRIES) begin
               r.block_index = entries[head];
            end else begin
               r.status = fce_pkg::STATUS_BAD_CHAIN;
            end
         end
         fce_pkg::OP_WRITE_ENTRY: begin
            if (head < fce_pkg::TABLE_ENTRIES) begin
               entries[head] = item.entry_value;
               r.block_index = item.entry_value;
            end else begin
               r.status = fce_pkg::STATUS_BAD_CHAIN;
            end
         end
         default: begin
            r.status = fce_pkg::STATUS_BAD_CHAIN;
         end
      endcase
      pending_results.push_back(r);
   endfunction

   task report_mismatch(input string text);
      $display("ERROR: %s", text);
      errors++;
   endtask

   task match_result(input fce_pkg::rsp_type got);
      fce_pkg::rsp_type want;
      checked++;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result %h arrived with nothing pending", got));
         return;
      end
      want = pending_results.pop_front();
      if (got.block_index !== want.block_index)
         report_mismatch($sformatf("result %0d block_index %h, want %h",
                                   checked, got.block_index, want.block_index));
      if (got.free_count !== want.free_count)
         report_mismatch($sformatf("result %0d free_count %h, want %h",
                                   checked, got.free_count, want.free_count));
      if (got.status !== want.status)
         report_mismatch($sformatf("result %0d status %h, want %h",
                                   checked, got.status, want.status));
   endtask
endclass

module tb_fat_chain_engine_top;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   fce_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   fce_pkg::rsp_type          rsp_data;
   logic                      csr_we = 1'b0;
   logic                      csr_index = fce_pkg::CSR_DATA_BLOCK_COUNT;
   logic [fce_pkg::CSR_W-1:0] csr_wdata = '0;

   fat_table_shadow  shadow;
   bit               idle_on = 1'b1;
   int               settings_used = 0;

   fat_chain_engine_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : result_sink
      int unsigned stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall != 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.match_result(rsp_data);
   end

   task automatic send_item(input fce_pkg::req_type item);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      shadow.apply_request(item);
      @(negedge clock);
   endtask

   task automatic issue(input fce_pkg::op_type op, input int unsigned head,
                        input int unsigned offset, input int unsigned value);
      fce_pkg::req_type item;
      item.op          = op;
      item.chain_head  = 12'(head);
      item.byte_offset = fce_pkg::OFS_W'(offset);
      item.entry_value = fce_pkg::ENTRY_W'(value);
      send_item(item);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (shadow.pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic program_layout(input int unsigned count, input int unsigned start);
      bit [fce_pkg::CSR_W-1:0] word;
      settle();
      word = {3'($urandom()), count[fce_pkg::DBC_W-1:0]};
      csr_we    <= 1'b1;
      csr_index <= fce_pkg::CSR_DATA_BLOCK_COUNT;
      csr_wdata <= word;
      @(negedge clock);
      shadow.write_register(fce_pkg::CSR_DATA_BLOCK_COUNT, word);
      csr_index <= fce_pkg::CSR_DATA_START;
      csr_wdata <= fce_pkg::CSR_W'(start);
      @(negedge clock);
      shadow.write_register(fce_pkg::CSR_DATA_START, fce_pkg::CSR_W'(start));
      csr_we <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   function automatic fce_pkg::req_type random_item();
      fce_pkg::req_type item;
      int unsigned      pick;
      int unsigned      lim;
      int unsigned      nheads;
      int unsigned      head;
      int unsigned      hop;
      lim = shadow.usable_limit();
      nheads = shadow.live_heads.size();
      item.op          = fce_pkg::OP_NEW_CHAIN;
      item.chain_head  = 12'($urandom());
      item.byte_offset = fce_pkg::OFS_W'($urandom());
      item.entry_value = fce_pkg::ENTRY_W'($urandom());
      head = (nheads != 0) ? shadow.live_heads[$urandom_range(0, nheads - 1)] : 0;
      pick = $urandom_range(0, 99);
      if (nheads > 12 && pick >= 15 && pick < 30) pick = 45;
      if (pick < 15 || (nheads == 0 && pick < 50)) begin
         item.op = fce_pkg::OP_NEW_CHAIN;
      end else if (pick < 40) begin
         item.op = fce_pkg::OP_APPEND;
         item.chain_head = 12'(head);
      end else if (pick < 50) begin
         item.op = fce_pkg::OP_FREE_CHAIN;
         item.chain_head = 12'(head);
      end else if (pick < 73) begin
         item.op = fce_pkg::OP_LOOKUP;
         if (nheads != 0) item.chain_head = 12'(head);
         hop = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
         item.byte_offset = {hop[11:0], 12'($urandom())};
      end else if (pick < 78) begin
         item.op = fce_pkg::OP_COUNT_FREE;
      end else if (pick < 86) begin
         item.op = fce_pkg::OP_READ_ENTRY;
         if ($urandom_range(0, 1) == 0) item.chain_head = 12'($urandom_range(0, lim - 1));
      end else if (pick < 92) begin
         item.op = fce_pkg::OP_WRITE_ENTRY;
         if ($urandom_range(0, 1) == 0) item.chain_head = 12'($urandom_range(0, lim - 1));
         case ($urandom_range(0, 3))
            0: item.entry_value = fce_pkg::ENTRY_FREE;
            1: item.entry_value = fce_pkg::CHAIN_END;
            2: item.entry_value = fce_pkg::ENTRY_W'($urandom_range(0, lim));
            default: item.entry_value = fce_pkg::ENTRY_W'($urandom());
         endcase
      end else begin
         item.op = 3'($urandom_range(0, 7));
      end
      return item;
   endfunction

   task automatic run_phase(input int unsigned count, input int unsigned start,
                            input int unsigned items);
      program_layout(count, start);
      repeat (items) send_item(random_item());
   endtask

   initial begin
      shadow = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue(fce_pkg::OP_COUNT_FREE, 0, 0, 0);
      issue(fce_pkg::OP_NEW_CHAIN, 0, 0, 0);
      issue(fce_pkg::OP_APPEND, 1, 0, 0);
      issue(fce_pkg::OP_APPEND, 1, 0, 0);
      issue(fce_pkg::OP_LOOKUP, 1, 0, 0);
      issue(fce_pkg::OP_LOOKUP, 1, 24'h001FFF, 0);
      issue(fce_pkg::OP_LOOKUP, 1, 24'h003000, 0);
      issue(fce_pkg::OP_LOOKUP, 1, 24'hFFFFFF, 0);
      issue(fce_pkg::OP_LOOKUP, 0, 0, 0);
      issue(fce_pkg::OP_APPEND, 4095, 0, 0);
      issue(fce_pkg::OP_READ_ENTRY, 0, 0, 0);
      issue(fce_pkg::OP_WRITE_ENTRY, 4095, 0, 16'hFFFF);
      issue(fce_pkg::OP_FREE_CHAIN, 4095, 0, 0);
      issue(fce_pkg::OP_WRITE_ENTRY, 2, 0, 16'd5000);
      issue(fce_pkg::OP_LOOKUP, 1, 24'h002000, 0);
      issue(fce_pkg::OP_FREE_CHAIN, 1, 0, 0);
      issue(fce_pkg::OP_FREE_CHAIN, 0, 0, 0);
      issue(fce_pkg::OP_UNUSED, 12'hFFF, 24'hFFFFFF, 16'hFFFF);

      program_layout(2, 16'hFFFF);
      issue(fce_pkg::OP_NEW_CHAIN, 0, 0, 0);
      issue(fce_pkg::OP_NEW_CHAIN, 0, 0, 0);
      issue(fce_pkg::OP_APPEND, 1, 0, 0);
      issue(fce_pkg::OP_LOOKUP, 1, 0, 0);
      issue(fce_pkg::OP_WRITE_ENTRY, 1, 0, 1);
      issue(fce_pkg::OP_APPEND, 1, 0, 0);
      issue(fce_pkg::OP_LOOKUP, 1, 24'h005000, 0);
      issue(fce_pkg::OP_FREE_CHAIN, 1, 0, 0);
      issue(fce_pkg::OP_COUNT_FREE, 0, 0, 0);

      run_phase(16, $urandom(), 200);
      run_phase(64, 0, 150);
      run_phase(3, 16'hFFFF, 80);
      run_phase(300, $urandom(), 180);
      run_phase(4096, $urandom(), 40);
      run_phase(1, $urandom(), 20);
      settle();
      idle_on = 1'b0;
      run_phase(128, $urandom(), 120);

      settle();
      repeat (64) @(negedge clock);
      if (shadow.pending_results.size() != 0)
         shadow.report_mismatch($sformatf("%0d results never arrived",
                                          shadow.pending_results.size()));
      $display("Run covered %0d items and %0d results under %0d register settings.",
               shadow.accepted, shadow.checked, settings_used);
      $display("Layouts ranged from a single reserved entry to the full table.");
      if (shadow.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
